>>> sv/wpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

   // Store depths.
   localparam int PATTERN_DEPTH = 64;
   localparam int SUBJECT_DEPTH = 256;

   // Store address widths; a single-entry store still gets one address bit.
   localparam int PAT_AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int SUBJ_AW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;

   // Counter widths. The pattern cursor runs up to the pattern length. The
   // subject cursor and the resume point can reach one past the subject length.
   localparam int PAT_CW = $clog2(PATTERN_DEPTH + 1);
   localparam int SUBJ_CW = $clog2(SUBJECT_DEPTH + 2);

   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
   localparam logic [BYTE_W-1:0] ANY_BYTE = 8'h3F;

   typedef enum logic [1:0] {
      CMD_PATTERN = 2'd0,
      CMD_SUBJECT = 2'd1,
      CMD_EVAL    = 2'd2,
      CMD_CLEAR   = 2'd3
   } wpm_cmd_type;

   typedef enum logic [3:0] {
      OP_NOP         = 4'd0,
      OP_APPEND_PAT  = 4'd1,
      OP_APPEND_SUBJ = 4'd2,
      OP_CLEAR_PAT   = 4'd3,
      OP_INIT        = 4'd4,
      OP_STAR        = 4'd5,
      OP_ADVANCE     = 4'd6,
      OP_BACKTRACK   = 4'd7,
      OP_SKIP_STAR   = 4'd8,
      OP_RESULT      = 4'd9,
      OP_FINISH      = 4'd10
   } wpm_op_type;

   typedef struct packed {
      wpm_op_type op;
      logic       result;
   } wpm_dp_cmd_type;

   typedef struct packed {
      logic subj_left;   // subject cursor below subject length
      logic pat_left;    // pattern cursor below pattern length
      logic at_star;     // pattern byte under the cursor is a star
      logic fits;        // pattern byte accepts the subject byte
      logic star_last;   // the star is the final pattern byte
      logic star_seen;   // a backtrack point exists
   } wpm_dp_status_type;

endpackage

`default_nettype wire

>>> sv/wildcard_pattern_match_unit.sv
// Pattern, subject and clear beats are taken one beat per cycle while the unit is idle.
// Evaluate: each walk step is a registered read of both byte stores, then a compare
// and cursor update; a start step comes before the walk and a result load after it.
// A walk takes up to about (pattern length + 1) x (subject length + 1) steps, and the
// load waits while an earlier result is still held; no beat is taken until it is done.
// Reset (synchronous) empties both stores and clears the drop flag; store bytes are kept.
`timescale 1ns / 1ps
`default_nettype none

// Glob matcher. The pattern and the subject are loaded one byte per beat into
// two byte memories. An evaluate beat starts a walk over both memories: the
// controller reads the byte under each cursor, decides in the next cycle
// whether to skip a star, advance both cursors, or backtrack to just after the
// most recent star one subject byte further on, and repeats until the answer
// is known. The answer is then loaded into an output register as soon as that
// register is free or is being emptied, and new beats are taken from the next
// cycle on, even while that result still waits to be collected.
// After an evaluate the subject and the drop flag are cleared; the pattern is
// kept until a clear beat.
module wildcard_pattern_match_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [wpm_pkg::BYTE_W-1:0]      req_char_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_matched,
   output logic                                 rsp_overflow
);

   wpm_pkg::wpm_dp_cmd_type    dp_cmd;
   wpm_pkg::wpm_dp_status_type dp_status;

   // The controller sequences the walk and owns both handshakes.
   wpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // The datapath holds the stores, lengths, cursors and the result register.
   wpm_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_char_in  (req_char_in),
      .dp_cmd       (dp_cmd),
      .dp_status    (dp_status),
      .rsp_matched  (rsp_matched),
      .rsp_overflow (rsp_overflow)
   );

endmodule

`default_nettype wire

>>> sv/wpm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module wpm_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic [wpm_pkg::BYTE_W-1:0]              req_char_in,
   input  wire wpm_pkg::wpm_dp_cmd_type                 dp_cmd,
   output wpm_pkg::wpm_dp_status_type                   dp_status,
   output logic                                         rsp_matched,
   output logic                                         rsp_overflow
);

   logic [wpm_pkg::BYTE_W-1:0] pat_mem [wpm_pkg::PATTERN_DEPTH];
   logic [wpm_pkg::BYTE_W-1:0] subj_mem [wpm_pkg::SUBJECT_DEPTH];

   logic [wpm_pkg::BYTE_W-1:0]  pat_rd_ff;
   logic [wpm_pkg::BYTE_W-1:0]  subj_rd_ff;

   logic [wpm_pkg::PAT_CW-1:0]  plen_ff, plen_in;
   logic [wpm_pkg::SUBJ_CW-1:0] slen_ff, slen_in;
   logic                        ovf_ff, ovf_in;
   logic                        seen_ff, seen_in;

   logic [wpm_pkg::PAT_CW-1:0]  w_ff, w_in;
   logic [wpm_pkg::PAT_CW-1:0]  star_next_ff, star_next_in;
   logic [wpm_pkg::SUBJ_CW-1:0] s_ff, s_in;
   logic [wpm_pkg::SUBJ_CW-1:0] resume_ff, resume_in;
   logic                        match_ff, match_in;
   logic                        rsp_matched_ff, rsp_matched_in;
   logic                        rsp_overflow_ff, rsp_overflow_in;

   logic pat_full;
   logic subj_full;
   logic pat_wr;
   logic subj_wr;
   logic [wpm_pkg::PAT_CW-1:0] w_plus;

   assign pat_full  = (plen_ff == wpm_pkg::PAT_CW'(wpm_pkg::PATTERN_DEPTH));
   assign subj_full = (slen_ff == wpm_pkg::SUBJ_CW'(wpm_pkg::SUBJECT_DEPTH));
   assign pat_wr    = (dp_cmd.op == wpm_pkg::OP_APPEND_PAT) && !pat_full;
   assign subj_wr   = (dp_cmd.op == wpm_pkg::OP_APPEND_SUBJ) && !subj_full;
   assign w_plus    = wpm_pkg::PAT_CW'(w_ff + 1'b1);

   // Byte stores: one write port and one registered read port each. The read
   // addresses follow the walk cursors every cycle.
   always_ff @(posedge clock) begin
      if (pat_wr) begin
         pat_mem[plen_ff[wpm_pkg::PAT_AW-1:0]] <= req_char_in;
      end
      if (subj_wr) begin
         subj_mem[slen_ff[wpm_pkg::SUBJ_AW-1:0]] <= req_char_in;
      end
      pat_rd_ff  <= pat_mem[w_ff[wpm_pkg::PAT_AW-1:0]];
      subj_rd_ff <= subj_mem[s_ff[wpm_pkg::SUBJ_AW-1:0]];
   end

   always_comb begin
      plen_in         = plen_ff;
      slen_in         = slen_ff;
      ovf_in          = ovf_ff;
      seen_in         = seen_ff;
      w_in            = w_ff;
      star_next_in    = star_next_ff;
      s_in            = s_ff;
      resume_in       = resume_ff;
      match_in        = match_ff;
      rsp_matched_in  = rsp_matched_ff;
      rsp_overflow_in = rsp_overflow_ff;
      case (dp_cmd.op)
         wpm_pkg::OP_APPEND_PAT: begin
            if (pat_full) begin
               ovf_in = 1'b1;
            end else begin
               plen_in = wpm_pkg::PAT_CW'(plen_ff + 1'b1);
            end
         end
         wpm_pkg::OP_APPEND_SUBJ: begin
            if (subj_full) begin
               ovf_in = 1'b1;
            end else begin
               slen_in = wpm_pkg::SUBJ_CW'(slen_ff + 1'b1);
            end
         end
         wpm_pkg::OP_CLEAR_PAT: begin
            plen_in = '0;
         end
         wpm_pkg::OP_INIT: begin
            w_in    = '0;
            s_in    = '0;
            seen_in = 1'b0;
         end
         wpm_pkg::OP_STAR: begin
            w_in         = w_plus;
            star_next_in = w_plus;
            resume_in    = wpm_pkg::SUBJ_CW'(s_ff + 1'b1);
            seen_in      = 1'b1;
         end
         wpm_pkg::OP_ADVANCE: begin
            w_in = w_plus;
            s_in = wpm_pkg::SUBJ_CW'(s_ff + 1'b1);
         end
         wpm_pkg::OP_BACKTRACK: begin
            w_in      = star_next_ff;
            s_in      = resume_ff;
            resume_in = wpm_pkg::SUBJ_CW'(resume_ff + 1'b1);
         end
         wpm_pkg::OP_SKIP_STAR: begin
            w_in = w_plus;
         end
         wpm_pkg::OP_RESULT: begin
            match_in = dp_cmd.result;
         end
         wpm_pkg::OP_FINISH: begin
            rsp_matched_in  = match_ff;
            rsp_overflow_in = ovf_ff;
            slen_in         = '0;
            ovf_in          = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         slen_ff <= '0;
         ovf_ff  <= 1'b0;
         seen_ff <= 1'b0;
      end else begin
         plen_ff <= plen_in;
         slen_ff <= slen_in;
         ovf_ff  <= ovf_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff            <= w_in;
      star_next_ff    <= star_next_in;
      s_ff            <= s_in;
      resume_ff       <= resume_in;
      match_ff        <= match_in;
      rsp_matched_ff  <= rsp_matched_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   always_comb begin
      dp_status.subj_left = (s_ff < slen_ff);
      dp_status.pat_left  = (w_ff < plen_ff);
      dp_status.at_star   = dp_status.pat_left && (pat_rd_ff == wpm_pkg::STAR_BYTE);
      dp_status.fits      = dp_status.pat_left && dp_status.subj_left &&
                            ((pat_rd_ff == subj_rd_ff) || (pat_rd_ff == wpm_pkg::ANY_BYTE));
      dp_status.star_last = (w_plus == plen_ff);
      dp_status.star_seen = seen_ff;
   end

   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

`default_nettype wire

>>> sv/wpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wpm_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [1:0]                   req_cmd,
   output logic                              req_ready,
   input  wire logic                         rsp_ready,
   output logic                              rsp_valid,
   output wpm_pkg::wpm_dp_cmd_type           dp_cmd,
   input  wire wpm_pkg::wpm_dp_status_type   dp_status
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_STEP  = 4'b0100,
      ST_DONE  = 4'b1000
   } wpm_state_type;

   wpm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      dp_cmd.op     = wpm_pkg::OP_NOP;
      dp_cmd.result = 1'b0;
      req_ready     = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (wpm_pkg::wpm_cmd_type'(req_cmd))
                  wpm_pkg::CMD_PATTERN: dp_cmd.op = wpm_pkg::OP_APPEND_PAT;
                  wpm_pkg::CMD_SUBJECT: dp_cmd.op = wpm_pkg::OP_APPEND_SUBJ;
                  wpm_pkg::CMD_CLEAR:   dp_cmd.op = wpm_pkg::OP_CLEAR_PAT;
                  wpm_pkg::CMD_EVAL: begin
                     dp_cmd.op = wpm_pkg::OP_INIT;
                     state_in  = ST_FETCH;
                  end
                  default: dp_cmd.op = wpm_pkg::OP_NOP;
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (dp_status.subj_left) begin
               if (dp_status.at_star) begin
                  if (dp_status.star_last) begin
                     dp_cmd.op     = wpm_pkg::OP_RESULT;
                     dp_cmd.result = 1'b1;
                     state_in      = ST_DONE;
                  end else begin
                     dp_cmd.op = wpm_pkg::OP_STAR;
                     state_in  = ST_FETCH;
                  end
               end else if (dp_status.fits) begin
                  dp_cmd.op = wpm_pkg::OP_ADVANCE;
                  state_in  = ST_FETCH;
               end else if (!dp_status.star_seen) begin
                  dp_cmd.op     = wpm_pkg::OP_RESULT;
                  dp_cmd.result = 1'b0;
                  state_in      = ST_DONE;
               end else begin
                  dp_cmd.op = wpm_pkg::OP_BACKTRACK;
                  state_in  = ST_FETCH;
               end
            end else if (dp_status.at_star) begin
               dp_cmd.op = wpm_pkg::OP_SKIP_STAR;
               state_in  = ST_FETCH;
            end else begin
               dp_cmd.op     = wpm_pkg::OP_RESULT;
               dp_cmd.result = !dp_status.pat_left;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.op = wpm_pkg::OP_FINISH;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.op == wpm_pkg::OP_FINISH) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> sv/wpm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wpm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_cmd,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_matched,
   input wire logic       rsp_overflow
);

   // A stalled result beat stays offered.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");

   // A stalled result beat keeps its payload.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_matched) && $stable(rsp_overflow))
      else $error("result payload changed while stalled");

   // An evaluate beat starts a walk, so no beat is taken in the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == wpm_pkg::CMD_EVAL) |=> !req_ready)
      else $error("request taken during a walk");

   // No result appears in the cycle straight after an accepted beat.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result beat without a finished walk");

endmodule

bind wildcard_pattern_match_unit wpm_checker u_wpm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_cmd      (req_cmd),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_matched  (rsp_matched),
   .rsp_overflow (rsp_overflow)
);

`default_nettype wire

>>> dv/wpm_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the glob matcher, keeps its own copy of the two
// byte stores and predicts the verdict of every evaluate beat.
module wpm_scoreboard (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic [1:0]                 req_cmd,
   input  wire logic [wpm_pkg::BYTE_W-1:0] req_char_in,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic                       rsp_matched,
   input  wire logic                       rsp_overflow,
   output int                              fail_count,
   output int                              pending
);

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   logic [wpm_pkg::BYTE_W-1:0] pat_mem [wpm_pkg::PATTERN_DEPTH];
   logic [wpm_pkg::BYTE_W-1:0] subj_mem [wpm_pkg::SUBJECT_DEPTH];
   int                         pat_len = 0;
   int                         subj_len = 0;
   logic                       dropped = 1'b0;
   verdict_type                verdicts_due [$];
   int                         errors = 0;

   function automatic bit star_at(input int w);
      return w < pat_len && pat_mem[w] == wpm_pkg::STAR_BYTE;
   endfunction

   function automatic bit byte_accepts(input int w, input int s);
      if (w >= pat_len || s >= subj_len)
         return 1'b0;
      return pat_mem[w] == subj_mem[s] || pat_mem[w] == wpm_pkg::ANY_BYTE;
   endfunction

   // Single-star backtracking walk: on a mismatch, go back to just after the
   // latest star and retry one subject byte further on.
   function automatic bit glob_matches();
      int w;
      int s;
      int after_star;
      int retry_at;
      w = 0;
      s = 0;
      after_star = 0;
      retry_at = 0;
      while (s < subj_len && !star_at(w)) begin
         if (!byte_accepts(w, s))
            return 1'b0;
         w++;
         s++;
      end
      while (s < subj_len) begin
         if (star_at(w)) begin
            w++;
            if (w >= pat_len)
               return 1'b1;
            after_star = w;
            retry_at = s + 1;
         end else if (byte_accepts(w, s)) begin
            w++;
            s++;
         end else begin
            w = after_star;
            s = retry_at;
            retry_at++;
         end
      end
      while (star_at(w))
         w++;
      return w >= pat_len;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         pat_len = 0;
         subj_len = 0;
         dropped = 1'b0;
         verdicts_due.delete();
      end else begin
         // The result register is fed by earlier beats only, so check it first.
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               $error("result beat with no evaluate outstanding");
               errors++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_matched !== want.matched) begin
                  $error("matched: expected %0b, got %0b", want.matched, rsp_matched);
                  errors++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (wpm_pkg::wpm_cmd_type'(req_cmd))
               wpm_pkg::CMD_PATTERN: begin
                  if (pat_len < wpm_pkg::PATTERN_DEPTH) begin
                     pat_mem[pat_len] = req_char_in;
                     pat_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               wpm_pkg::CMD_SUBJECT: begin
                  if (subj_len < wpm_pkg::SUBJECT_DEPTH) begin
                     subj_mem[subj_len] = req_char_in;
                     subj_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               wpm_pkg::CMD_EVAL: begin
                  want.matched = glob_matches();
                  want.overflow = dropped;
                  verdicts_due = {verdicts_due, want};
                  subj_len = 0;
                  dropped = 1'b0;
               end
               default: begin
                  pat_len = 0;
               end
            endcase
         end
      end
      fail_count <= errors;
      pending <= verdicts_due.size();
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

// Testbench for the glob matcher. This module only produces beats and gives
// the verdict; the checker instantiated beside the block predicts and compares.
module tb;

   localparam int ITEM_TARGET = 1250;
   // The final stretch of beats runs with no idling on either side.
   localparam int QUIET_TAIL = 150;
   // A full-size walk takes roughly 65 x 257 steps, so an idle limit of this size
   // leaves a wide margin above any correct run.
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER = 20;
   localparam int DRAIN_CYCLES = 20;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [1:0]                 req_cmd;
   logic [wpm_pkg::BYTE_W-1:0] req_char_in;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_matched;
   logic                       rsp_overflow;

   int                         fail_count;
   int                         pending;
   int                         beats_offered = 0;
   int                         gap_rate = 0;
   int                         idle_cycles = 0;
   bit                         quiet = 1'b0;
   // Copy of the pattern as sent, used only to build subjects that stand a
   // fair chance of matching.
   logic [wpm_pkg::BYTE_W-1:0] pat_copy [$];

   wildcard_pattern_match_unit uut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_cmd,
      .req_char_in,
      .rsp_valid,
      .rsp_ready,
      .rsp_matched,
      .rsp_overflow
   );

   wpm_scoreboard match_check (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_cmd,
      .req_char_in,
      .rsp_valid,
      .rsp_ready,
      .rsp_matched,
      .rsp_overflow,
      .fail_count,
      .pending
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Pattern bytes lean towards stars, question marks and a two-letter
   // alphabet, so that the walk backtracks often; now and then any byte.
   function automatic logic [wpm_pkg::BYTE_W-1:0] pattern_char();
      case ($urandom_range(0, 9))
         0, 1:    return wpm_pkg::STAR_BYTE;
         2:       return wpm_pkg::ANY_BYTE;
         3, 4, 5: return "a";
         6, 7:    return "b";
         default: return wpm_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [wpm_pkg::BYTE_W-1:0] subject_char();
      case ($urandom_range(0, 7))
         0, 1, 2: return "a";
         3, 4:    return "b";
         default: return wpm_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Offers one beat and returns once it has been accepted. Valid is only
   // lowered when an idle burst is wanted, so it never drops and rises within
   // the same time step.
   task automatic offer(input wpm_pkg::wpm_cmd_type cmd,
                        input logic [wpm_pkg::BYTE_W-1:0] ch);
      if (!quiet && $urandom_range(0, 9) < gap_rate) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_char_in <= ch;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      case (cmd)
         wpm_pkg::CMD_PATTERN: pat_copy = {pat_copy, ch};
         wpm_pkg::CMD_CLEAR:   pat_copy.delete();
         default:              ;
      endcase
      beats_offered++;
      if (beats_offered >= ITEM_TARGET - QUIET_TAIL)
         quiet = 1'b1;
   endtask

   task automatic feed(input wpm_pkg::wpm_cmd_type cmd, input string text);
      for (int i = 0; i < text.len(); i++)
         offer(cmd, text[i]);
   endtask

   task automatic load_pattern(input int len);
      offer(wpm_pkg::CMD_CLEAR, wpm_pkg::BYTE_W'($urandom_range(0, 255)));
      repeat (len)
         offer(wpm_pkg::CMD_PATTERN, pattern_char());
   endtask

   // A subject either follows the current pattern (stars become short runs,
   // question marks become any byte, and a stray byte is sometimes added to
   // spoil the match) or is plain random text of the given length.
   task automatic load_subject(input int len, input bit follow);
      if (follow) begin
         foreach (pat_copy[i]) begin
            if (pat_copy[i] == wpm_pkg::STAR_BYTE)
               repeat ($urandom_range(0, 3)) offer(wpm_pkg::CMD_SUBJECT, subject_char());
            else if (pat_copy[i] == wpm_pkg::ANY_BYTE)
               offer(wpm_pkg::CMD_SUBJECT, wpm_pkg::BYTE_W'($urandom_range(0, 255)));
            else
               offer(wpm_pkg::CMD_SUBJECT, pat_copy[i]);
         end
         if ($urandom_range(0, 3) == 0)
            offer(wpm_pkg::CMD_SUBJECT, subject_char());
      end else begin
         repeat (len)
            offer(wpm_pkg::CMD_SUBJECT, subject_char());
      end
   endtask

   // Stimulus.
   initial begin
      int scene;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= wpm_pkg::CMD_PATTERN;
      req_char_in <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed beats. Empty pattern against an empty subject, then against
      // a non-empty one.
      offer(wpm_pkg::CMD_EVAL, 8'h00);
      feed(wpm_pkg::CMD_SUBJECT, "x");
      offer(wpm_pkg::CMD_EVAL, 8'hFF);
      // A pattern of stars alone matches an empty subject.
      feed(wpm_pkg::CMD_PATTERN, "**");
      offer(wpm_pkg::CMD_EVAL, 8'h55);
      // A question mark takes a zero byte, and the star has to backtrack
      // past a false 'c'.
      offer(wpm_pkg::CMD_CLEAR, 8'hAA);
      feed(wpm_pkg::CMD_PATTERN, "a?*c");
      offer(wpm_pkg::CMD_SUBJECT, "a");
      offer(wpm_pkg::CMD_SUBJECT, 8'h00);
      feed(wpm_pkg::CMD_SUBJECT, "bcc");
      offer(wpm_pkg::CMD_EVAL, 8'h00);
      // Extreme byte values compared as ordinary literals.
      offer(wpm_pkg::CMD_CLEAR, 8'hFF);
      offer(wpm_pkg::CMD_PATTERN, 8'h00);
      offer(wpm_pkg::CMD_PATTERN, wpm_pkg::STAR_BYTE);
      offer(wpm_pkg::CMD_PATTERN, 8'hFF);
      offer(wpm_pkg::CMD_SUBJECT, 8'h00);
      offer(wpm_pkg::CMD_SUBJECT, 8'h7F);
      offer(wpm_pkg::CMD_SUBJECT, 8'hFF);
      offer(wpm_pkg::CMD_EVAL, 8'h80);

      // Random scenes: a new pattern now and then, a subject, sometimes a few
      // stray beats of any kind, then an evaluate. A handful of scenes load one of the
      // stores to around or past its depth, so that the drop flag can be exercised.
      scene = 0;
      while (beats_offered < ITEM_TARGET) begin
         gap_rate = $urandom_range(0, 3);
         if (scene == 5 || scene == 30)
            load_pattern($urandom_range(62, 70));
         else if (scene == 0 || $urandom_range(0, 3) == 0)
            load_pattern($urandom_range(0, 8));
         if (scene == 15 || scene == 40)
            load_subject($urandom_range(250, 262), 1'b0);
         else
            load_subject($urandom_range(0, 10), $urandom_range(0, 1));
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3))
               offer(wpm_pkg::wpm_cmd_type'($urandom_range(0, 3)),
                     wpm_pkg::BYTE_W'($urandom_range(0, 255)));
         offer(wpm_pkg::CMD_EVAL, wpm_pkg::BYTE_W'($urandom_range(0, 255)));
         scene++;
      end
      req_valid <= 1'b0;

      // Let the scoreboard update first, so that its count of outstanding verdicts includes
      // the last accepted beat.
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   // Result side. Ready drops in short random bursts until the tail of the
   // run. Once, after some results have been taken, it is held low for a long
   // stretch while beats keep coming, so that the block fills and stalls its
   // input.
   initial begin
      int  beats_taken;
      bit  held;
      beats_taken = 0;
      held = 1'b0;
      rsp_ready <= 1'b0;
      do
         @(posedge clock);
      while (reset);
      forever begin
         if (!held && beats_taken >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
            if (rsp_valid && rsp_ready)
               beats_taken++;
         end
      end
   end

   // Watchdog: counts edges at which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
